// File: sv/i2cms_pkg.sv
// Package for the I2C master bit sequencer: command codes and field widths.
`default_nettype none
package i2cms_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned BIT_W   = 3;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_START = 3'd0;
  localparam func_t FUNC_STOP  = 3'd1;
  localparam func_t FUNC_WRITE = 3'd2;
  localparam func_t FUNC_WACK  = 3'd3;
  localparam func_t FUNC_NACK  = 3'd4;

  localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = 16'd10;

  // Phase position inside a bit slot, and the last bit of a byte.
  localparam logic [PHASE_W-1:0] PH_FIRST = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MID   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LAST  = 2'd2;
  localparam logic [BIT_W-1:0]   BIT_LAST = 3'd7;

endpackage
`default_nettype wire

// File: sv/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer: turns bus commands into timed SCL/SDA phases.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  in_      | in  | in_valid / in_ready    | in_func, in_data_byte, in_sda_in
//  out_     | out | out_valid / out_ready  | out_scl_level, out_sda_level,
//           |     |                        | out_ack_missing, out_last
//  cfg_     | in  | cfg_wr_en (no wait)    | cfg_wr_data = phase_ticks
//
// One command at a time; each phase is one output transfer, and the next phase
// waits out the programmed phase length after one is taken before it is offered.
// A write byte is 24 phases, start is 3 phases, stop 2, wait-ack and nack 3.
// The data byte shifts out one bit per bit slot; unused codes are taken and dropped.
// Reset (rst_n low, synchronous) idles the bus high, phase_ticks to 10; stalls hold.
`default_nettype none
module i2c_master_bit_sequencer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command transfer
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [i2cms_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                          in_sda_in,
  // phase transfer
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_scl_level,
  output logic                               out_sda_level,
  output logic                               out_ack_missing,
  output logic                               out_last,
  // phase length register
  input  wire logic                          cfg_wr_en,
  input  wire logic [i2cms_pkg::TICKS_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOLD,
    ST_EMIT
  } state_t;

  state_t                            state_r;
  logic [i2cms_pkg::TICKS_W-1:0]     phase_ticks_r;
  logic [i2cms_pkg::TICKS_W-1:0]     tick_r;
  i2cms_pkg::func_t                  func_r;
  logic [i2cms_pkg::BYTE_W-1:0]      shift_r;
  logic                              sda_seen_r;
  logic [i2cms_pkg::PHASE_W-1:0]     phase_r;
  logic [i2cms_pkg::BIT_W-1:0]       bit_r;
  logic                              scl_now_r;

  logic                              out_valid_r;
  logic                              out_scl_r;
  logic                              out_sda_r;
  logic                              out_nack_r;
  logic                              out_last_r;

  // Levels of the phase the counters point at.
  logic ph_scl, ph_sda, ph_nack, ph_last;
  logic cur_bit;
  logic func_ok;
  logic tick_done;

  assign cur_bit   = shift_r[i2cms_pkg::BYTE_W-1];
  assign func_ok   = (in_func <= i2cms_pkg::FUNC_NACK);
  assign tick_done = (tick_r <= i2cms_pkg::TICKS_W'(1));

  always_comb begin
    ph_scl  = 1'b1;
    ph_sda  = 1'b1;
    ph_nack = 1'b0;
    ph_last = 1'b0;
    unique case (func_r)
      i2cms_pkg::FUNC_START: begin
        ph_scl  = (phase_r != i2cms_pkg::PH_LAST);
        ph_sda  = (phase_r == i2cms_pkg::PH_FIRST);
        ph_last = (phase_r == i2cms_pkg::PH_LAST);
      end
      i2cms_pkg::FUNC_STOP: begin
        ph_scl  = 1'b1;
        ph_sda  = (phase_r == i2cms_pkg::PH_MID);
        ph_last = (phase_r == i2cms_pkg::PH_MID);
      end
      i2cms_pkg::FUNC_WRITE: begin
        // SDA is released on the falling edge after the eighth bit
        ph_scl  = (phase_r == i2cms_pkg::PH_FIRST) ? scl_now_r
                                                   : (phase_r == i2cms_pkg::PH_MID);
        ph_sda  = ((phase_r == i2cms_pkg::PH_LAST) && (bit_r == i2cms_pkg::BIT_LAST))
                  ? 1'b1 : cur_bit;
        ph_last = (phase_r == i2cms_pkg::PH_LAST) && (bit_r == i2cms_pkg::BIT_LAST);
      end
      i2cms_pkg::FUNC_WACK,
      i2cms_pkg::FUNC_NACK: begin
        ph_scl  = (phase_r == i2cms_pkg::PH_FIRST) ? scl_now_r
                                                   : (phase_r == i2cms_pkg::PH_MID);
        ph_sda  = 1'b1;
        ph_last = (phase_r == i2cms_pkg::PH_LAST);
        ph_nack = (phase_r == i2cms_pkg::PH_LAST) &&
                  (func_r == i2cms_pkg::FUNC_WACK) && sda_seen_r;
      end
      default: begin
        ph_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_ticks_r <= i2cms_pkg::PHASE_TICKS_RST;
      tick_r        <= '0;
      scl_now_r     <= 1'b1;
      out_valid_r   <= 1'b0;
      phase_r       <= i2cms_pkg::PH_FIRST;
      bit_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        phase_ticks_r <= cfg_wr_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && func_ok) begin
            func_r     <= in_func;
            shift_r    <= in_data_byte;
            sda_seen_r <= in_sda_in;
            phase_r    <= i2cms_pkg::PH_FIRST;
            bit_r      <= '0;
            tick_r     <= '0;
            state_r    <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (tick_done) begin
            out_scl_r   <= ph_scl;
            out_sda_r   <= ph_sda;
            out_nack_r  <= ph_nack;
            out_last_r  <= ph_last;
            out_valid_r <= 1'b1;
            scl_now_r   <= ph_scl;
            state_r     <= ST_EMIT;
          end else begin
            tick_r <= tick_r - i2cms_pkg::TICKS_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              tick_r  <= phase_ticks_r;
              state_r <= ST_HOLD;
              if (phase_r == i2cms_pkg::PH_LAST) begin
                phase_r <= i2cms_pkg::PH_FIRST;
                bit_r   <= bit_r + i2cms_pkg::BIT_W'(1);
                shift_r <= {shift_r[i2cms_pkg::BYTE_W-2:0], 1'b0};
              end else begin
                phase_r <= phase_r + i2cms_pkg::PHASE_W'(1);
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_scl_level   = out_scl_r;
  assign out_sda_level   = out_sda_r;
  assign out_ack_missing = out_nack_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// File: verif/i2c_master_bit_sequencer_core_test.sv
// Self-checking testbench for the I2C master bit sequencer: predicted bus phases vs. the core.
module i2c_master_bit_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver hold used to back the core up while the sender keeps offering.
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic scl;
    logic sda;
    logic ack_missing;
    logic last;
  } bus_phase_t;

  // Predicts the phase stream from accepted commands and checks each phase
  // transfer against the oldest prediction.
  class phase_scoreboard;
    bus_phase_t phase_q[$];
    logic       scl_now;
    logic       sda_now;
    int         errors;

    function new();
      scl_now = 1'b1;
      sda_now = 1'b1;
      errors  = 0;
    endfunction

    function void push_phase(logic scl, logic sda, logic nack, logic fin);
      bus_phase_t p;
      p.scl         = scl;
      p.sda         = sda;
      p.ack_missing = nack;
      p.last        = fin;
      phase_q.push_back(p);
      scl_now = scl;
      sda_now = sda;
    endfunction

    function void note_command(i2cms_pkg::func_t func,
                               logic [i2cms_pkg::BYTE_W-1:0] data, logic sda_seen);
      logic bit_val;
      case (func)
        i2cms_pkg::FUNC_START: begin
          push_phase(1'b1, 1'b1, 1'b0, 1'b0);
          push_phase(1'b1, 1'b0, 1'b0, 1'b0);
          push_phase(1'b0, 1'b0, 1'b0, 1'b1);
        end
        i2cms_pkg::FUNC_STOP: begin
          push_phase(1'b1, 1'b0, 1'b0, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, 1'b1);
        end
        i2cms_pkg::FUNC_WRITE: begin
          // MSB first; SCL keeps its level into the first bit only
          for (int i = i2cms_pkg::BYTE_W - 1; i >= 0; i--) begin
            bit_val = data[i];
            push_phase(scl_now, bit_val, 1'b0, 1'b0);
            push_phase(1'b1, bit_val, 1'b0, 1'b0);
            // after the eighth bit SDA is released for the ack slot
            push_phase(1'b0, (i == 0) ? 1'b1 : bit_val, 1'b0, i == 0);
          end
        end
        i2cms_pkg::FUNC_WACK: begin
          push_phase(scl_now, 1'b1, 1'b0, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, 1'b0);
          push_phase(1'b0, 1'b1, sda_seen, 1'b1);
        end
        i2cms_pkg::FUNC_NACK: begin
          push_phase(scl_now, 1'b1, 1'b0, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, 1'b0);
          push_phase(1'b0, 1'b1, 1'b0, 1'b1);
        end
        default: ;  // unused codes: dropped, state unchanged
      endcase
    endfunction

    function void check_field(string name, logic want, logic got);
      if (want !== got) begin
        $error("%s: expected %0b, got %0b", name, want, got);
        errors++;
      end
    endfunction

    function void check_phase(logic scl, logic sda, logic nack, logic fin);
      bus_phase_t want;
      if (phase_q.size() == 0) begin
        $error("phase transfer with nothing expected: scl=%0b sda=%0b ack_missing=%0b last=%0b",
               scl, sda, nack, fin);
        errors++;
        return;
      end
      want = phase_q.pop_front();
      check_field("scl_level", want.scl, scl);
      check_field("sda_level", want.sda, sda);
      check_field("ack_missing", want.ack_missing, nack);
      check_field("last", want.last, fin);
    endfunction

    function int pending();
      return phase_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input starts at a known level.
  // ---------------------------------------------------------------------------
  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_ready;
  i2cms_pkg::func_t              in_func         = i2cms_pkg::FUNC_START;
  logic [i2cms_pkg::BYTE_W-1:0]  in_data_byte    = '0;
  logic                          in_sda_in       = 1'b0;
  logic                          out_valid;
  logic                          out_ready       = 1'b0;
  logic                          out_scl_level;
  logic                          out_sda_level;
  logic                          out_ack_missing;
  logic                          out_last;
  logic                          cfg_wr_en       = 1'b0;
  logic [i2cms_pkg::TICKS_W-1:0] cfg_wr_data     = i2cms_pkg::PHASE_TICKS_RST;

  phase_scoreboard sb = new();

  int items_sent = 0;                                // commands the core acts on
  int cur_ticks  = int'(i2cms_pkg::PHASE_TICKS_RST); // phase length currently programmed
  bit tx_quiet   = 1'b0;              // sender offers back to back
  int hold_asked = 0;                 // bumped by stimulus to request a long hold
  int hold_done  = 0;
  int rx_stall   = 0;
  int rx_calm    = 0;

  always #10 clk = ~clk;

  i2c_master_bit_sequencer_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_data_byte    (in_data_byte),
    .in_sda_in       (in_sda_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scl_level   (out_scl_level),
    .out_sda_level   (out_sda_level),
    .out_ack_missing (out_ack_missing),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 11) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [i2cms_pkg::BYTE_W-1:0] rand_byte();
    return i2cms_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Phase sink: checks every phase transfer and drives out_ready. Random
  // stalls, calm stretches without any, and the long hold requested by the
  // stimulus are all counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_phase(out_scl_level, out_sda_level, out_ack_missing, out_last);

    if (rx_calm > 0)
      rx_calm--;
    else if ($urandom_range(0, 99) == 0)
      rx_calm = $urandom_range(50, 200);

    if (rx_stall == 0 && hold_done != hold_asked) begin
      hold_done = hold_asked;
      rx_stall  = LONG_HOLD;
    end else if (rx_stall == 0 && rx_calm == 0 && $urandom_range(0, 3) == 0) begin
      rx_stall = pick_gap();
    end

    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver. Returns in the time step of the transfer with in_valid
  // still high; the next call (or settle) lowers or reuses it in that same
  // step, so a command is never offered twice.
  // ---------------------------------------------------------------------------
  task automatic send_command(input i2cms_pkg::func_t func,
                              input logic [i2cms_pkg::BYTE_W-1:0] data,
                              input logic sda_seen);
    int gap;
    gap = (tx_quiet || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data;
    in_sda_in    <= sda_seen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(func, data, sda_seen);
    if (func <= i2cms_pkg::FUNC_NACK) items_sent++;
  endtask

  // Stop offering, wait for every predicted phase, then give the core time to
  // finish its last phase hold (and any dropped command) before going on.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (cur_ticks + 8) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [i2cms_pkg::TICKS_W-1:0] ticks);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_ticks = int'(ticks);
  endtask

  // Random garbage command, unused codes included.
  task automatic noise_item();
    send_command(i2cms_pkg::func_t'($urandom_range(0, 7)), rand_byte(), rand_bit());
  endtask

  // One bus transaction with random content: start, 1-3 bytes each with an
  // ack check (usually acked), maybe a nack, and usually a stop. Leaving the
  // stop out makes the next start a repeated start.
  task automatic run_transaction();
    int nbytes;
    nbytes = $urandom_range(1, 3);
    if ($urandom_range(0, 4) == 0) noise_item();
    send_command(i2cms_pkg::FUNC_START, rand_byte(), rand_bit());
    repeat (nbytes) begin
      send_command(i2cms_pkg::FUNC_WRITE, rand_byte(), rand_bit());
      send_command(i2cms_pkg::FUNC_WACK, rand_byte(), $urandom_range(0, 3) == 0);
    end
    if ($urandom_range(0, 2) == 0)
      send_command(i2cms_pkg::FUNC_NACK, rand_byte(), rand_bit());
    if ($urandom_range(0, 5) != 0)
      send_command(i2cms_pkg::FUNC_STOP, rand_byte(), rand_bit());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [i2cms_pkg::TICKS_W-1:0] tick_plan[7];
    tick_plan = '{16'd1, 16'd3, 16'd10, 16'd0, 16'd6, 16'd2, 16'd17};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset phase length: bus idle high, so a write, wait-ack or
    // nack right after stop must start with SCL high.
    send_command(i2cms_pkg::FUNC_START, 8'h00, 1'b0);
    send_command(i2cms_pkg::FUNC_WRITE, 8'h00, 1'b0);
    send_command(i2cms_pkg::FUNC_WACK,  8'h00, 1'b0);
    send_command(i2cms_pkg::FUNC_WRITE, 8'hFF, 1'b1);
    send_command(i2cms_pkg::FUNC_WACK,  8'hFF, 1'b1);
    send_command(i2cms_pkg::FUNC_WRITE, 8'hA5, 1'b0);
    send_command(i2cms_pkg::FUNC_NACK,  8'hFF, 1'b1);
    send_command(i2cms_pkg::FUNC_STOP,  8'h00, 1'b0);
    send_command(i2cms_pkg::FUNC_WRITE, 8'h5A, 1'b1);
    send_command(i2cms_pkg::FUNC_WACK,  8'h5A, 1'b1);
    send_command(i2cms_pkg::FUNC_STOP,  8'hFF, 1'b1);
    send_command(i2cms_pkg::FUNC_WACK,  8'h80, 1'b0);
    send_command(i2cms_pkg::FUNC_STOP,  8'h00, 1'b0);
    send_command(i2cms_pkg::FUNC_NACK,  8'h01, 1'b0);
    // unused command codes: must vanish without a phase
    send_command(i2cms_pkg::func_t'(5), 8'hFF, 1'b1);
    send_command(i2cms_pkg::func_t'(6), 8'h00, 1'b0);
    send_command(i2cms_pkg::func_t'(7), 8'hC3, 1'b1);
    send_command(i2cms_pkg::FUNC_START, 8'hFF, 1'b1);
    send_command(i2cms_pkg::FUNC_START, 8'h00, 1'b0);   // repeated start
    send_command(i2cms_pkg::FUNC_WRITE, 8'h80, 1'b0);
    send_command(i2cms_pkg::FUNC_STOP,  8'h00, 1'b1);

    // Zero phase length is handled like the shortest nonzero length; results unchanged.
    set_phase_ticks(16'd0);
    send_command(i2cms_pkg::FUNC_START, 8'h00, 1'b0);
    send_command(i2cms_pkg::FUNC_WRITE, 8'h3C, 1'b0);
    send_command(i2cms_pkg::FUNC_WACK,  8'h00, 1'b1);
    send_command(i2cms_pkg::FUNC_STOP,  8'h00, 1'b0);

    // Longest phase: only a two-phase stop, to keep the run short.
    set_phase_ticks(16'hFFFF);
    send_command(i2cms_pkg::FUNC_STOP, 8'h00, 1'b0);

    // Random part, several phase lengths.
    foreach (tick_plan[k]) begin
      set_phase_ticks(tick_plan[k]);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (k == 0) begin
        // long receiver hold with commands offered back to back: the core
        // stays busy and has to hold off the sender
        tx_quiet = 1'b1;
        hold_asked <= hold_asked + 1;
        send_command(i2cms_pkg::FUNC_START, 8'h00, 1'b0);
        send_command(i2cms_pkg::FUNC_WRITE, rand_byte(), 1'b0);
        send_command(i2cms_pkg::FUNC_WACK,  8'h00, 1'b1);
        send_command(i2cms_pkg::FUNC_STOP,  8'h00, 1'b0);
        tx_quiet = 1'b0;
      end
      while (items_sent < 30 + (k + 1) * 10) begin
        run_transaction();
        if ($urandom_range(0, 9) == 0) settle();
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
